// ===== hdl/gaa_pkg.sv =====
`default_nettype none

package gaa_pkg;

  localparam int HIST_DEPTH = 3;
  localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);
  localparam int NODE_COUNT_DEF = 8;
  localparam int PREEMPT_LIGHT_DELTA_DEF = 50;
  localparam int NODE_MASK_W = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    KIND_OBSERVE = 2'd0,
    KIND_VISION  = 2'd1,
    KIND_EVAL    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    MATCH_NONE   = 2'd0,
    MATCH_OK     = 2'd1,
    MATCH_ACTION = 2'd2
  } match_t;

  typedef enum logic [1:0] {
    TREND_NONE = 2'd0,
    TREND_RISE = 2'd1,
    TREND_FALL = 2'd2,
    TREND_FLAT = 2'd3
  } trend_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FAN_ON_TEMP   = 3'd0,
    CFG_FAN_OFF_TEMP  = 3'd1,
    CFG_PUMP_ON_SOIL  = 3'd2,
    CFG_LED_ON_LIGHT  = 3'd3,
    CFG_DAY_START     = 3'd4,
    CFG_DAY_END       = 3'd5,
    CFG_DARK_BRIGHT   = 3'd6,
    CFG_PREEMPT_DELTA = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [4:0]             pad;
    logic [NODE_MASK_W-1:0] offline_mask;
    logic [2:0]             actuator_bits;
    logic                   executor_ok;
    logic [7:0]             cam_brightness;
    logic                   cam_available;
    logic [4:0]             hour;
    logic                   sensor_valid;
    logic [15:0]            soil_moisture;
    logic [15:0]            light_level;
    logic signed [15:0]     temperature;
  } in_item_t;

  typedef struct packed {
    logic       pad;
    logic [3:0] anomaly_bits;
    logic       vision_backs_lamp;
    logic       preempt_lamp;
    logic       preempt_fan;
    trend_t     light_slope;
    trend_t     temp_slope;
    match_t     lamp_match;
    match_t     pump_match;
    match_t     fan_match;
    act_t       lamp_action;
    act_t       pump_action;
    act_t       fan_action;
  } result_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [15:0]        light;
    logic [15:0]        soil;
  } sample_t;

  function automatic trend_t trend3(input logic signed [16:0] a, input logic signed [16:0] b,
                                    input logic signed [16:0] c);
    trend_t t;
    if (a < b && b < c) begin
      t = TREND_RISE;
    end else if (a > b && b > c) begin
      t = TREND_FALL;
    end else begin
      t = TREND_FLAT;
    end
    return t;
  endfunction

  function automatic match_t match_of(input act_t action, input logic exec_ok, input logic on);
    match_t m;
    if (!exec_ok || action == ACT_NONE) begin
      m = MATCH_NONE;
    end else if ((action == ACT_ON && on) || (action == ACT_OFF && !on)) begin
      m = MATCH_OK;
    end else begin
      m = MATCH_ACTION;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/greenhouse_actuator_advisor.sv =====
`default_nettype none

// Advises on fan, pump and fill light from threshold rules, a daytime window,
// a three-sample sensor history and the last camera report. Requests carry a
// kind in in_tuser: observe (sensor_valid samples enter the history), vision
// (camera state is stored) and evaluate (one result request on out_*). Kind 3
// is dropped. The block takes one request per cycle while out_tready stays
// high. A request is held in the input register, where history and camera
// state are updated or the advice is computed; an evaluate result is then
// loaded into the output register, which drives out_tvalid. An evaluate
// request that finds an earlier result still held by a low out_tready waits
// in the input register and holds in_tready low until the output register
// frees. Configuration is written through cfg_*; the user must do so only
// while no request is in flight, as the block itself does not enforce it.
module greenhouse_actuator_advisor #(
  parameter int NODE_COUNT          = gaa_pkg::NODE_COUNT_DEF,
  parameter int PREEMPT_LIGHT_DELTA = gaa_pkg::PREEMPT_LIGHT_DELTA_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // temperature, light_level, soil_moisture, sensor_valid, hour, cam_available,
  // cam_brightness, executor_ok, actuator_bits, offline_mask, zero fill
  input  wire logic [gaa_pkg::IN_DATA_W-1:0]    in_tdata,
  // kind
  input  wire logic [1:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // fan_action, pump_action, lamp_action, fan_match, pump_match, lamp_match,
  // temp_slope, light_slope, preempt_fan, preempt_lamp, vision_backs_lamp,
  // anomaly_bits, zero fill
  output logic [gaa_pkg::OUT_DATA_W-1:0]        out_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [gaa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [gaa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import gaa_pkg::*;

  logic signed [15:0] fan_on_temp_r;
  logic signed [15:0] fan_off_temp_r;
  logic [15:0]        pump_on_soil_r;
  logic [15:0]        led_on_light_r;
  logic [4:0]         day_start_r;
  logic [4:0]         day_end_r;
  logic [7:0]         dark_bright_r;
  logic [14:0]        preempt_delta_r;

  sample_t               hist_r [HIST_DEPTH];
  logic [HIST_CNT_W-1:0] hist_cnt_r;
  logic                  vision_valid_r;
  logic [7:0]            vision_level_r;

  logic     s1_v_r;
  kind_t    s1_kind_r;
  in_item_t s1_r;
  logic     out_v_r;
  result_t  out_r;
  result_t  res_nxt;

  logic out_free;
  logic s1_eval;
  logic s1_adv;
  logic full;
  logic dark_cam;
  logic lamp;
  logic node_offline;
  logic signed [17:0] fan_pre;
  logic signed [17:0] temp_ext;
  logic [16:0]        light_pre;
  sample_t            s1_sample;

  assign out_free   = !out_v_r || out_tready;
  assign s1_eval    = s1_kind_r == KIND_EVAL;
  assign s1_adv     = s1_v_r && (!s1_eval || out_free);
  assign in_tready  = !s1_v_r || s1_adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  assign full         = hist_cnt_r == HIST_CNT_W'(HIST_DEPTH);
  assign dark_cam     = vision_level_r < dark_bright_r;
  assign node_offline = |s1_r.offline_mask[NODE_COUNT-1:0];
  assign fan_pre      = {{2{fan_on_temp_r[15]}}, fan_on_temp_r} - {3'b000, preempt_delta_r};
  assign temp_ext     = {{2{s1_r.temperature[15]}}, s1_r.temperature};
  assign light_pre    = {1'b0, led_on_light_r} + 17'(PREEMPT_LIGHT_DELTA);
  assign s1_sample    = '{temp: s1_r.temperature, light: s1_r.light_level,
                          soil: s1_r.soil_moisture};
  assign lamp = s1_r.hour >= day_start_r && s1_r.hour < day_end_r &&
                s1_r.light_level < led_on_light_r && (!vision_valid_r || dark_cam);

  always_comb begin
    res_nxt = '0;
    if (s1_r.sensor_valid) begin
      if (s1_r.temperature > fan_on_temp_r) begin
        res_nxt.fan_action = ACT_ON;
      end else if (s1_r.temperature < fan_off_temp_r) begin
        res_nxt.fan_action = ACT_OFF;
      end
      res_nxt.pump_action = (s1_r.soil_moisture < pump_on_soil_r) ? ACT_ON : ACT_OFF;
      res_nxt.lamp_action = lamp ? ACT_ON : ACT_OFF;
      if (full) begin
        res_nxt.temp_slope  = trend3(17'(hist_r[0].temp), 17'(hist_r[1].temp),
                                     17'(hist_r[2].temp));
        res_nxt.light_slope = trend3(signed'({1'b0, hist_r[0].light}),
                                     signed'({1'b0, hist_r[1].light}),
                                     signed'({1'b0, hist_r[2].light}));
      end
      res_nxt.preempt_fan  = res_nxt.temp_slope == TREND_RISE && temp_ext >= fan_pre;
      res_nxt.preempt_lamp = res_nxt.light_slope == TREND_FALL &&
                             {1'b0, s1_r.light_level} <= light_pre;
      res_nxt.vision_backs_lamp = lamp && vision_valid_r && dark_cam;
      res_nxt.fan_match  = match_of(res_nxt.fan_action, s1_r.executor_ok,
                                    s1_r.actuator_bits[0]);
      res_nxt.pump_match = match_of(res_nxt.pump_action, s1_r.executor_ok,
                                    s1_r.actuator_bits[1]);
      res_nxt.lamp_match = match_of(res_nxt.lamp_action, s1_r.executor_ok,
                                    s1_r.actuator_bits[2]);
      if (s1_r.executor_ok && full) begin
        res_nxt.anomaly_bits[1] = s1_r.actuator_bits[0] && hist_r[2].temp >= hist_r[0].temp;
        res_nxt.anomaly_bits[2] = s1_r.actuator_bits[1] && hist_r[2].soil <= hist_r[0].soil;
        res_nxt.anomaly_bits[3] = s1_r.actuator_bits[2] && hist_r[2].light <= hist_r[0].light;
      end
    end
    res_nxt.anomaly_bits[0] = node_offline;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_on_temp_r   <= 16'sd300;
      fan_off_temp_r  <= 16'sd260;
      pump_on_soil_r  <= 16'd300;
      led_on_light_r  <= 16'd200;
      day_start_r     <= 5'd6;
      day_end_r       <= 5'd18;
      dark_bright_r   <= 8'd60;
      preempt_delta_r <= 15'd20;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FAN_ON_TEMP:   fan_on_temp_r   <= cfg_wdata;
        CFG_FAN_OFF_TEMP:  fan_off_temp_r  <= cfg_wdata;
        CFG_PUMP_ON_SOIL:  pump_on_soil_r  <= cfg_wdata;
        CFG_LED_ON_LIGHT:  led_on_light_r  <= cfg_wdata;
        CFG_DAY_START:     day_start_r     <= cfg_wdata[4:0];
        CFG_DAY_END:       day_end_r       <= cfg_wdata[4:0];
        CFG_DARK_BRIGHT:   dark_bright_r   <= cfg_wdata[7:0];
        CFG_PREEMPT_DELTA: preempt_delta_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      hist_cnt_r     <= '0;
      vision_valid_r <= 1'b0;
      vision_level_r <= '0;
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (out_free) begin
        out_v_r <= s1_v_r && s1_eval;
      end
      if (s1_adv) begin
        case (s1_kind_r)
          KIND_OBSERVE: begin
            if (s1_r.sensor_valid && !full) begin
              hist_cnt_r <= hist_cnt_r + 1'b1;
            end
          end
          KIND_VISION: begin
            vision_valid_r <= s1_r.cam_available;
            vision_level_r <= s1_r.cam_brightness;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_r      <= in_item_t'(in_tdata);
      s1_kind_r <= kind_t'(in_tuser);
    end
    if (out_free && s1_v_r && s1_eval) begin
      out_r <= res_nxt;
    end
    if (s1_adv && s1_kind_r == KIND_OBSERVE && s1_r.sensor_valid) begin
      if (!full) begin
        hist_r[hist_cnt_r] <= s1_sample;
      end else begin
        for (int i = 1; i < HIST_DEPTH; i++) begin
          hist_r[i-1] <= hist_r[i];
        end
        hist_r[HIST_DEPTH-1] <= s1_sample;
      end
    end
  end

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_kind_r == KIND_OBSERVE && s1_r.sensor_valid && !full)
    |=> hist_cnt_r == $past(hist_cnt_r) + 1'b1)
    else $error("history count did not advance on a sample");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    hist_cnt_r <= HIST_CNT_W'(HIST_DEPTH))
    else $error("history count above depth");

  a_trend_sensor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.temp_slope != TREND_NONE) |-> out_r.pump_action != ACT_NONE)
    else $error("trend given without a sensor report");

  a_preempt: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((!out_r.preempt_fan || out_r.temp_slope == TREND_RISE) &&
                 (!out_r.preempt_lamp || out_r.light_slope == TREND_FALL)))
    else $error("preemptive flag without matching trend");

  a_vision: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.vision_backs_lamp) |-> out_r.lamp_action == ACT_ON)
    else $error("vision support without lamp on");

  a_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.fan_match != MATCH_NONE) |-> out_r.fan_action != ACT_NONE)
    else $error("fan match status without fan advice");

endmodule

`default_nettype wire
